@@ design/cross_stencil_free_cell_count_defines.svh @@
// ============================================================================
// Cross stencil free cell count - assertion macros
// Concurrent checks on clk with rst_n low as the disable condition; the
// synthesis view of each macro is empty.
// ============================================================================
`ifndef CROSS_STENCIL_FREE_CELL_COUNT_DEFINES_SVH
`define CROSS_STENCIL_FREE_CELL_COUNT_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold in the same cycle
`define CSFCC_ASSERT_NOW(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next
`define CSFCC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CSFCC_ASSERT_NOW(name, prop, msg)
`define CSFCC_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

@@ design/csfcc_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// csfcc_pkg
// Shared widths, codes and the request bundles between the counter core
// and the row buffers.
// ============================================================================
package csfcc_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CHAR_W    = 8;
  localparam int COUNT_W   = 21;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'b1;

  // character that marks a free cell
  localparam logic [CHAR_W-1:0] FREE_CHAR = 8'd46;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // write request into both row buffers at the current column
  typedef struct packed {
    logic we;
    logic prev_bit;
    logic older_bit;
  } rowbuf_wr_t;

  // registered row buffer reads for the current column
  typedef struct packed {
    logic above;   // previous row, this column
    logic right;   // previous row, next column
    logic up;      // row before previous, this column
  } rowbuf_rd_t;

endpackage

@@ design/cross_stencil_free_cell_count.sv @@
`timescale 1ns / 1ps
`include "cross_stencil_free_cell_count_defines.svh"
// ============================================================================
// cross_stencil_free_cell_count
// Counts free cells whose in-grid cross neighbours are all free, one frame
// of raster-order characters at a time.
// ============================================================================
// Takes one cell per clock with no gaps needed; each cell passes through one
// level of logic between the position/row-buffer registers and the count
// register. The frame total appears on the output register the cycle after
// the frame's last cell is accepted. The input stalls only when the next
// cell closes a frame while the previous total is still waiting downstream.
// The two row buffers are one-bit RAMs of MAX_COLUMNS entries with one
// write and registered reads per cycle; they need no clearing pass, so the
// block takes cells right after reset.
module cross_stencil_free_cell_count #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [csfcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csfcc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [csfcc_pkg::CHAR_W-1:0]    in_cell_char,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [csfcc_pkg::COUNT_W-1:0]   out_free_cell_count
);
  import csfcc_pkg::*;

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [CFG_W-1:0]   grid_columns_r;
  logic [CFG_W-1:0]   grid_rows_r;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r;

  logic               in_fire;
  logic               frame_end;
  logic               res_fire;
  logic [COUNT_W-1:0] res_count;
  rowbuf_wr_t         buf_wr;
  rowbuf_rd_t         buf_rd;
  logic [AW-1:0]      buf_wr_addr;
  logic [AW-1:0]      buf_rd_addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r <= CFG_W'(1);
      grid_rows_r    <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_COLUMNS: grid_columns_r <= cfg_wdata;
        REG_GRID_ROWS:    grid_rows_r    <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // hold the frame's last cell while the previous total waits
  assign in_stall = out_valid_r && out_stall && frame_end;
  assign in_fire  = in_valid && !in_stall;

  csfcc_core #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .AW          (AW)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .grid_columns (grid_columns_r),
    .grid_rows    (grid_rows_r),
    .in_fire      (in_fire),
    .cell_char    (in_cell_char),
    .rd           (buf_rd),
    .wr           (buf_wr),
    .wr_addr      (buf_wr_addr),
    .rd_addr      (buf_rd_addr),
    .frame_end    (frame_end),
    .res_fire     (res_fire),
    .res_count    (res_count)
  );

  csfcc_linebuf #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .AW          (AW)
  ) u_linebuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (buf_wr),
    .wr_addr (buf_wr_addr),
    .rd_addr (buf_rd_addr),
    .rd      (buf_rd)
  );

  // output register: load a new total, drop the old one when taken
  assign out_valid_nxt = (out_valid_r && out_stall) || res_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_count_r <= res_count;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_free_cell_count = out_count_r;

  `CSFCC_ASSERT_NEXT(a_result_shown, res_fire, out_valid_r,
                     "frame total not presented")
  `CSFCC_ASSERT_NOW(a_no_overwrite, !(res_fire && out_valid_r && out_stall),
                    "pending total overwritten")
  `CSFCC_ASSERT_NOW(a_rise_from_frame, !$rose(out_valid_r) || $past(res_fire),
                    "output request without a finished frame")

endmodule

@@ design/csfcc_linebuf.sv @@
`timescale 1ns / 1ps
// ============================================================================
// csfcc_linebuf
// Two one-bit line buffers (previous row and the row before it) with
// registered reads and write-first forwarding on an address match.
// ============================================================================
module csfcc_linebuf #(
  parameter int MAX_COLUMNS = 1024,
  parameter int AW          = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csfcc_pkg::rowbuf_wr_t  wr,
  input  logic [AW-1:0]          wr_addr,
  input  logic [AW-1:0]          rd_addr,
  output csfcc_pkg::rowbuf_rd_t  rd
);
  import csfcc_pkg::*;

  logic           prev_mem [MAX_COLUMNS];
  logic           older_mem [MAX_COLUMNS];

  logic [AW:0]    rd_next_wide;
  logic [AW-1:0]  rd_next_addr;

  logic           prev_a_r;
  logic           prev_b_r;
  logic           older_a_r;
  logic           byp_a_r;
  logic           byp_b_r;
  logic           wr_prev_r;
  logic           wr_older_r;

  // second read port looks one column ahead
  assign rd_next_wide = {1'b0, rd_addr} + (AW+1)'(1);
  assign rd_next_addr = (rd_next_wide >= (AW+1)'(MAX_COLUMNS)) ? '0 : rd_next_wide[AW-1:0];

  // write both rows, read registered
  always_ff @(posedge clk) begin
    if (wr.we) begin
      prev_mem[wr_addr]  <= wr.prev_bit;
      older_mem[wr_addr] <= wr.older_bit;
    end
    prev_a_r   <= prev_mem[rd_addr];
    prev_b_r   <= prev_mem[rd_next_addr];
    older_a_r  <= older_mem[rd_addr];
    wr_prev_r  <= wr.prev_bit;
    wr_older_r <= wr.older_bit;
  end

  // flag reads that collide with the write in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_a_r <= 1'b0;
      byp_b_r <= 1'b0;
    end else begin
      byp_a_r <= wr.we && (wr_addr == rd_addr);
      byp_b_r <= wr.we && (wr_addr == rd_next_addr);
    end
  end

  // forward the freshly written bits
  assign rd.above = byp_a_r ? wr_prev_r  : prev_a_r;
  assign rd.right = byp_b_r ? wr_prev_r  : prev_b_r;
  assign rd.up    = byp_a_r ? wr_older_r : older_a_r;

endmodule

@@ design/csfcc_core.sv @@
`timescale 1ns / 1ps
`include "cross_stencil_free_cell_count_defines.svh"
// ============================================================================
// csfcc_core
// Raster position, three-cell window and the saturating frame count.
// Evaluates the cross stencil for up to three centres per accepted cell.
// ============================================================================
module csfcc_core #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int AW          = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [csfcc_pkg::CFG_W-1:0]   grid_columns,
  input  logic [csfcc_pkg::CFG_W-1:0]   grid_rows,
  input  logic                          in_fire,
  input  logic [csfcc_pkg::CHAR_W-1:0]  cell_char,
  input  csfcc_pkg::rowbuf_rd_t         rd,
  output csfcc_pkg::rowbuf_wr_t         wr,
  output logic [AW-1:0]                 wr_addr,
  output logic [AW-1:0]                 rd_addr,
  output logic                          frame_end,
  output logic                          res_fire,
  output logic [csfcc_pkg::COUNT_W-1:0] res_count
);
  import csfcc_pkg::*;

  localparam int RAW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CLOGC = $clog2(MAX_COLUMNS + 1);
  localparam int CLOGR = $clog2(MAX_ROWS + 1);
  localparam int CFW   = (CFG_W > CLOGC) ? CFG_W : CLOGC;
  localparam int RFW   = (CFG_W > CLOGR) ? CFG_W : CLOGR;

  logic [AW-1:0]      col_r, col_nxt;
  logic [RAW-1:0]     row_r, row_nxt;
  logic [2:0]         win_r, win_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic [CFW-1:0]     cols_ext, cols_eff, col_plus;
  logic [RFW-1:0]     rows_ext, rows_eff, row_plus;
  logic               last_col, last_row;
  logic               col_ge1, col_ge2, row_ge1, row_ge2, right_in;
  logic               free_bit;
  logic               t_up, t_cur, t_last;
  logic [1:0]         tally_sum;
  logic [COUNT_W:0]   count_sum;
  logic [COUNT_W-1:0] count_sat;

  // clamp grid size: zero acts as one, oversize acts as the maximum
  assign cols_ext = CFW'(grid_columns);
  assign rows_ext = RFW'(grid_rows);
  assign cols_eff = (cols_ext == '0) ? CFW'(1) :
                    (cols_ext > CFW'(MAX_COLUMNS)) ? CFW'(MAX_COLUMNS) : cols_ext;
  assign rows_eff = (rows_ext == '0) ? RFW'(1) :
                    (rows_ext > RFW'(MAX_ROWS)) ? RFW'(MAX_ROWS) : rows_ext;

  // position tests, "at or past the end" ends the row or frame
  assign col_plus  = CFW'(col_r) + CFW'(1);
  assign row_plus  = RFW'(row_r) + RFW'(1);
  assign last_col  = (col_plus >= cols_eff);
  assign last_row  = (row_plus >= rows_eff);
  assign frame_end = last_col && last_row;
  assign col_ge1   = (col_r != '0);
  assign col_ge2   = (CFW'(col_r) >= CFW'(2));
  assign row_ge1   = (row_r != '0);
  assign row_ge2   = (RFW'(row_r) >= RFW'(2));
  assign right_in  = !last_col && (col_plus < CFW'(MAX_COLUMNS));
  assign free_bit  = (cell_char == FREE_CHAR);

  // centre one row up; upper-left neighbour sits in the window
  assign t_up = row_ge1 && rd.above && (row_ge2 ? rd.up : 1'b1) && free_bit &&
                (col_ge1 ? win_r[2] : 1'b1) && (right_in ? rd.right : 1'b1);

  // bottom row: the cell to the left, its upper neighbour is window bit 2
  assign t_cur = last_row && col_ge1 && win_r[0] && (row_ge1 ? win_r[2] : 1'b1) &&
                 (col_ge2 ? win_r[1] : 1'b1) && free_bit;

  // bottom-right corner cell itself
  assign t_last = frame_end && free_bit && (row_ge1 ? rd.above : 1'b1) &&
                  (col_ge1 ? win_r[0] : 1'b1);

  // add up to three hits, saturate
  assign tally_sum = 2'(t_up) + 2'(t_cur) + 2'(t_last);
  assign count_sum = {1'b0, count_r} + (COUNT_W+1)'(tally_sum);
  assign count_sat = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[COUNT_W-1:0];

  // next state for one accepted cell
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    win_nxt   = win_r;
    count_nxt = count_r;
    if (in_fire) begin
      win_nxt   = {rd.above, win_r[0], free_bit};
      count_nxt = count_sat;
      if (last_col) begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt   = '0;
          count_nxt = '0;
        end else begin
          row_nxt = row_r + RAW'(1);
        end
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      win_r   <= '0;
      count_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      win_r   <= win_nxt;
      count_r <= count_nxt;
    end
  end

  // shift the line buffers at this column, prefetch the next one
  assign wr.we        = in_fire;
  assign wr.prev_bit  = free_bit;
  assign wr.older_bit = rd.above;
  assign wr_addr      = col_r;
  assign rd_addr      = col_nxt;

  assign res_fire  = in_fire && frame_end;
  assign res_count = count_sat;

  `CSFCC_ASSERT_NEXT(a_col_wrap, in_fire && last_col, col_r == '0,
                     "column did not wrap after row end")
  `CSFCC_ASSERT_NEXT(a_frame_clear, res_fire, (count_r == '0) && (row_r == '0),
                     "frame state not cleared after result")
  `CSFCC_ASSERT_NEXT(a_hold_idle, !in_fire,
                     $stable(col_r) && $stable(row_r) && $stable(count_r),
                     "state moved without an accepted cell")

endmodule
